// File: hdl/lifo_stack_with_peek_core_assert.svh
// assertion macros shared by the stack rtl
`ifndef LIFO_STACK_WITH_PEEK_CORE_ASSERT_SVH
`define LIFO_STACK_WITH_PEEK_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LSP_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsp same-cycle check failed");

// next-cycle implication, checked out of reset
`define LSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsp next-cycle check failed");

`endif

// File: hdl/lsp_pkg.sv
// types and constants shared by the stack rtl
package lsp_pkg;

    localparam int WORD_W  = 32;
    localparam int OP_W    = 3;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int LEVEL_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_TOP    = 3'd3,
        OP_BOTTOM = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
        logic load_scan;
        logic shift_scan;
    } cell_ctl_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        status_t            status;
        logic [WORD_W-1:0]  data;
    } res_t;

endpackage

// File: hdl/lsp_cell.sv
// one stack cell: a stored word plus a scan copy for deep reads
module lsp_cell
    import lsp_pkg::*;
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [WORD_W-1:0] push_in,
    input  logic [WORD_W-1:0] pop_in,
    input  logic [WORD_W-1:0] scan_in,
    output logic [WORD_W-1:0] data,
    output logic [WORD_W-1:0] scan
);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] scan_reg;

    // push moves words away from the top, pop moves them back
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            data_reg <= push_in;
        end
        else if (ctl.pop)
        begin
            data_reg <= pop_in;
        end

        if (ctl.load_scan)
        begin
            scan_reg <= data_reg;
        end
        else if (ctl.shift_scan)
        begin
            scan_reg <= scan_in;
        end
    end

    assign data = data_reg;
    assign scan = scan_reg;

endmodule

// File: hdl/lifo_stack_with_peek_core.sv
// bounded lifo stack with peek, built as a chain of shifting cells
//
//  channel   | direction | tdata (low bit up)              | tuser        | tlast
//  ----------+-----------+---------------------------------+--------------+------
//  s_axis    | in        | value[31:0], position[39:32]    | op[2:0]      | -
//  m_axis    | out       | data[31:0], level[38:32], pad   | status[1:0]  | -
//
//  push, pop, top, bottom and peek at position 0 or 1 are answered without a scan
//  and can follow each other every cycle while s_axis_tready stays high
//  peek at position p (2..count) copies the words into the scan cells, then the
//  scan chain moves the copied words one cell towards the top per cycle
//  reset clears the count, the sequencer and the output valids; stored words
//  are undefined until pushed
//  results sit in an output register backed by one skid entry; s_axis_tready
//  drops while the skid entry is full or a scan is running
`include "lifo_stack_with_peek_core_assert.svh"

module lifo_stack_with_peek_core
    import lsp_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // op[2:0]
    input  logic [2:0]  s_axis_tuser,
    // value[31:0], position[39:32]
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data[31:0], level[38:32], zero pad[39]
    output logic [39:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    // cell chain, index 0 holds the top of stack
    logic [WORD_W-1:0] cell_data [DEPTH];
    logic [WORD_W-1:0] cell_scan [DEPTH];
    cell_ctl_t         ctl;

    // sequencer and stack bookkeeping
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     remain_reg, remain_next;
    logic [WORD_W-1:0] bottom_reg;
    logic              bottom_we;

    // output register and skid entry
    res_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    res_t              skid_reg, skid_next;
    logic              skid_valid_reg, skid_valid_next;

    res_t              res;
    logic              res_valid;
    logic              in_acc;
    logic              out_acc;
    logic [WORD_W-1:0] in_value;
    logic [POS_W-1:0]  in_pos;
    logic [POS_W-1:0]  pos_eff;

    assign in_value = s_axis_tdata[WORD_W-1:0];
    assign in_pos   = s_axis_tdata[WORD_W+POS_W-1:WORD_W];
    assign pos_eff  = (in_pos == '0) ? POS_W'(1) : in_pos;

    assign s_axis_tready = (state_reg == S_IDLE) && !skid_valid_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = out_valid_reg && m_axis_tready;

    // the chain itself
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] push_src;
        logic [WORD_W-1:0] pop_src;
        logic [WORD_W-1:0] scan_src;

        if (i == 0)
        begin : g_first
            assign push_src = in_value;
        end
        else
        begin : g_rest
            assign push_src = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign pop_src  = '0;
            assign scan_src = '0;
        end
        else
        begin : g_inner
            assign pop_src  = cell_data[i+1];
            assign scan_src = cell_scan[i+1];
        end

        lsp_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .push_in (push_src),
            .pop_in  (pop_src),
            .scan_in (scan_src),
            .data    (cell_data[i]),
            .scan    (cell_scan[i])
        );
    end

    // request decode and scan sequencing
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        ctl         = '0;
        bottom_we   = 1'b0;
        res_valid   = 1'b0;
        res.data    = '0;
        res.status  = STAT_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_valid = 1'b1;
                    unique case (op_t'(s_axis_tuser))
                        OP_PUSH:
                        begin
                            if (count_reg == FULL)
                            begin
                                res.status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                ctl.push   = 1'b1;
                                bottom_we  = (count_reg == '0);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res.status = STAT_EMPTY;
                            end
                            else
                            begin
                                ctl.pop    = 1'b1;
                                res.data   = cell_data[0];
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (MW'(pos_eff) > MW'(count_reg))
                            begin
                                res.status = STAT_NOT_FOUND;
                                res.data   = '1;
                            end
                            else if (pos_eff == POS_W'(1))
                            begin
                                res.data = cell_data[0];
                            end
                            else
                            begin
                                // deep read: copy the chain, then walk it up
                                res_valid     = 1'b0;
                                ctl.load_scan = 1'b1;
                                remain_next   = CW'(pos_eff - 1'b1);
                                state_next    = S_SCAN;
                            end
                        end
                        OP_TOP:
                        begin
                            if (count_reg == '0)
                            begin
                                res.status = STAT_EMPTY;
                            end
                            else
                            begin
                                res.data = cell_data[0];
                            end
                        end
                        OP_BOTTOM:
                        begin
                            if (count_reg == '0)
                            begin
                                res.status = STAT_EMPTY;
                            end
                            else
                            begin
                                res.data = bottom_reg;
                            end
                        end
                        default:
                        begin
                            res.status = STAT_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (remain_reg == '0)
                begin
                    res_valid  = 1'b1;
                    res.data   = cell_scan[0];
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.shift_scan = 1'b1;
                    remain_next    = remain_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.level = LEVEL_W'(count_next);
    end

    // output register with one skid entry behind it
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (out_acc)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        if (res_valid)
        begin
            if (!out_valid_next)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            remain_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            remain_reg     <= remain_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
        if (bottom_we)
        begin
            bottom_reg <= in_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {1'b0, out_reg.level, out_reg.data};

    // checks
    `LSP_ASSERT_HOLDS(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL)
    `LSP_ASSERT_HOLDS(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `LSP_ASSERT_HOLDS(a_no_accept_in_scan, clk, rst_n, state_reg == S_SCAN, !s_axis_tready)
    `LSP_ASSERT_HOLDS(a_push_pop_excl, clk, rst_n, ctl.push, !ctl.pop && !ctl.shift_scan)
    `LSP_ASSERT_NEXT(a_push_grows, clk, rst_n, ctl.push, count_reg == $past(count_reg) + 1'b1)

endmodule
